@@ rtl/core/pett_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and sizing constants for the pending event tracker.
// Used by pett_ctrl, pett_dp and the top level; depends on nothing.

package pett_pkg;

  // Sizing defaults
  localparam int TableDepthDefault = 16;
  localparam logic [31:0] IdStart = 32'd1000;

  // Field widths
  localparam int CmdW    = 3;
  localparam int IdW     = 32;
  localparam int TmoW    = 17;
  localparam int ReasonW = 8;
  localparam int KindW   = 3;
  localparam int ExpW    = 32;

  // Command codes
  localparam logic [CmdW-1:0] CMD_AUTO     = 3'd0;
  localparam logic [CmdW-1:0] CMD_EXPLICIT = 3'd1;
  localparam logic [CmdW-1:0] CMD_ACK_OK   = 3'd2;
  localparam logic [CmdW-1:0] CMD_ACK_FAIL = 3'd3;
  localparam logic [CmdW-1:0] CMD_TICK     = 3'd4;

  // Result kinds
  localparam logic [KindW-1:0] KIND_REGISTERED = 3'd0;
  localparam logic [KindW-1:0] KIND_SUCCESS    = 3'd1;
  localparam logic [KindW-1:0] KIND_FAILURE    = 3'd2;
  localparam logic [KindW-1:0] KIND_TIMEOUT    = 3'd3;
  localparam logic [KindW-1:0] KIND_FULL       = 3'd4;
  localparam logic [KindW-1:0] KIND_DUPLICATE  = 3'd5;

  // Source of a result id
  typedef enum logic [1:0] {
    ID_CAND,
    ID_EVENT,
    ID_ZERO,
    ID_BEST
  } id_sel_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             scan_start;
    logic             scan_step;
    logic             cand_inc;
    logic             write_slot;
    logic             clear_hit;
    logic             clear_best;
    logic             emit;
    logic [KindW-1:0] emit_kind;
    id_sel_e          emit_id_sel;
    logic             emit_last;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            scan_done;
    logic            hit;
    logic            free_found;
    logic            exp_found;
    logic            exp_more;
    logic            out_fire;
  } dp_status_t;

endpackage

@@ rtl/core/pett_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module pett_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/pett_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the pending event tracker.
// Depends on pett_pkg; drives pett_dp through ctrl_cmd_t.

module pett_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pett_pkg::dp_status_t  status_i,
  output pett_pkg::ctrl_cmd_t   cmd_o
);

  pett_pkg::state_e state_q, state_d;
  logic more_q, more_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pett_pkg::ST_IDLE;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    more_d     = more_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit_id_sel = pett_pkg::ID_EVENT;
    case (state_q)
      pett_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pett_pkg::ST_LAUNCH;
        end
      end
      pett_pkg::ST_LAUNCH: begin
        if (status_i.cmd == pett_pkg::CMD_AUTO || status_i.cmd == pett_pkg::CMD_EXPLICIT ||
            status_i.cmd == pett_pkg::CMD_ACK_OK || status_i.cmd == pett_pkg::CMD_ACK_FAIL ||
            status_i.cmd == pett_pkg::CMD_TICK) begin
          cmd_o.scan_start = 1'b1;
          state_d          = pett_pkg::ST_SCAN;
        end else begin
          state_d = pett_pkg::ST_IDLE;
        end
      end
      pett_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = pett_pkg::ST_DECIDE;
        end
      end
      pett_pkg::ST_DECIDE: begin
        more_d         = 1'b0;
        cmd_o.emit_last = 1'b1;
        state_d        = pett_pkg::ST_OUT;
        case (status_i.cmd)
          pett_pkg::CMD_AUTO: begin
            if (!status_i.free_found) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_kind   = pett_pkg::KIND_FULL;
              cmd_o.emit_id_sel = pett_pkg::ID_ZERO;
            end else if (status_i.hit) begin
              // Candidate already held: step and scan again
              cmd_o.cand_inc = 1'b1;
              state_d        = pett_pkg::ST_LAUNCH;
            end else begin
              cmd_o.write_slot  = 1'b1;
              cmd_o.emit        = 1'b1;
              cmd_o.emit_kind   = pett_pkg::KIND_REGISTERED;
              cmd_o.emit_id_sel = pett_pkg::ID_CAND;
            end
          end
          pett_pkg::CMD_EXPLICIT: begin
            cmd_o.emit = 1'b1;
            if (status_i.hit) begin
              cmd_o.emit_kind = pett_pkg::KIND_DUPLICATE;
            end else if (!status_i.free_found) begin
              cmd_o.emit_kind = pett_pkg::KIND_FULL;
            end else begin
              cmd_o.write_slot = 1'b1;
              cmd_o.emit_kind  = pett_pkg::KIND_REGISTERED;
            end
          end
          pett_pkg::CMD_ACK_OK, pett_pkg::CMD_ACK_FAIL: begin
            if (status_i.hit) begin
              cmd_o.clear_hit = 1'b1;
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = (status_i.cmd == pett_pkg::CMD_ACK_OK) ?
                                pett_pkg::KIND_SUCCESS : pett_pkg::KIND_FAILURE;
            end else begin
              state_d = pett_pkg::ST_IDLE;
            end
          end
          pett_pkg::CMD_TICK: begin
            if (status_i.exp_found) begin
              cmd_o.clear_best  = 1'b1;
              cmd_o.emit        = 1'b1;
              cmd_o.emit_kind   = pett_pkg::KIND_TIMEOUT;
              cmd_o.emit_id_sel = pett_pkg::ID_BEST;
              cmd_o.emit_last   = !status_i.exp_more;
              more_d            = status_i.exp_more;
            end else begin
              state_d = pett_pkg::ST_IDLE;
            end
          end
          default: begin
            state_d = pett_pkg::ST_IDLE;
          end
        endcase
      end
      pett_pkg::ST_OUT: begin
        // Hold until the result transfer completes
        if (status_i.out_fire) begin
          state_d = more_q ? pett_pkg::ST_LAUNCH : pett_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pett_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/pett_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the pending event tracker: slot table, scan unit, counters
// and result register. Depends on pett_pkg and pett_ram.

module pett_dp #(
  parameter int TableDepth = pett_pkg::TableDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pett_pkg::ctrl_cmd_t               cmd_i,
  output pett_pkg::dp_status_t              status_o,
  input  logic [pett_pkg::CmdW-1:0]         in_cmd_i,
  input  logic [pett_pkg::IdW-1:0]          in_id_i,
  input  logic [pett_pkg::TmoW-1:0]         in_tmo_i,
  input  logic [pett_pkg::ReasonW-1:0]      in_reason_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pett_pkg::KindW-1:0]        out_kind_o,
  output logic [pett_pkg::IdW-1:0]          out_id_o,
  output logic [pett_pkg::ReasonW-1:0]      out_reason_o,
  output logic                              out_last_o
);

  localparam int IdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW  = $clog2(TableDepth + 1);
  localparam int IdW   = pett_pkg::IdW;
  localparam int ExpW  = pett_pkg::ExpW;
  localparam int EntW  = 1 + ExpW + IdW;
  localparam logic [CntW-1:0] ScanEnd = CntW'(TableDepth);

  // Latched item
  logic [pett_pkg::CmdW-1:0]    cmd_q;
  logic [IdW-1:0]               id_q;
  logic [pett_pkg::TmoW-1:0]    tmo_q;
  logic [pett_pkg::ReasonW-1:0] reason_q;

  // Persistent state
  logic [TableDepth-1:0] valid_q;
  logic [IdW-1:0]        next_id_q, cand_q;
  logic [ExpW-1:0]       time_q;

  // Scan state
  logic [CntW-1:0] scan_q;
  logic            rd_act_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            hit_q, free_q, found_q, more_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, best_idx_q;
  logic [IdW-1:0]  max_q, best_id_q;

  // Result register
  logic                         out_valid_q, out_last_q;
  logic [pett_pkg::KindW-1:0]   out_kind_q;
  logic [IdW-1:0]               out_id_q;
  logic [pett_pkg::ReasonW-1:0] out_reason_q;

  logic [EntW-1:0] rdata, wdata;
  logic            ent_v, ent_has;
  logic [ExpW-1:0] ent_exp;
  logic [IdW-1:0]  ent_id, key, new_id, max_new;
  logic            ent_hit, ent_free, ent_exp_hit, out_fire;
  logic [ExpW:0]   exp_sum;
  logic            new_has;
  logic [ExpW-1:0] new_exp;

  pett_ram #(
    .Width(EntW),
    .Depth(TableDepth)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write_slot),
    .waddr_i(free_idx_q),
    .wdata_i(wdata),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(rdata)
  );

  // Decode the entry under evaluation
  assign ent_id      = rdata[IdW-1:0];
  assign ent_exp     = rdata[IdW +: ExpW];
  assign ent_has     = rdata[EntW-1];
  assign ent_v       = valid_q[rd_idx_q];
  assign key         = (cmd_q == pett_pkg::CMD_AUTO) ? cand_q : id_q;
  assign ent_hit     = rd_act_q && ent_v && (ent_id == key);
  assign ent_free    = rd_act_q && !ent_v;
  assign ent_exp_hit = rd_act_q && ent_v && ent_has && (ent_exp < time_q);

  // New slot contents
  assign new_id  = (cmd_q == pett_pkg::CMD_AUTO) ? cand_q : id_q;
  assign exp_sum = {1'b0, time_q} + {{(ExpW + 1 - (pett_pkg::TmoW - 1)){1'b0}},
                                     tmo_q[pett_pkg::TmoW-2:0]};
  assign new_has = !tmo_q[pett_pkg::TmoW-1];
  assign new_exp = !new_has ? '0 : (exp_sum[ExpW] ? '1 : exp_sum[ExpW-1:0]);
  assign wdata   = {new_has, new_exp, new_id};
  assign max_new = (id_q > max_q) ? id_q : max_q;

  assign out_fire = out_valid_q && out_ready_i;

  // Item latch, time and id counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= '0;
      time_q    <= '0;
      next_id_q <= pett_pkg::IdStart;
      cand_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        cmd_q <= in_cmd_i;
        if (in_cmd_i == pett_pkg::CMD_TICK && time_q != '1) begin
          time_q <= time_q + 1'b1;
        end
        if (in_cmd_i == pett_pkg::CMD_AUTO) begin
          cand_q <= next_id_q;
        end
      end
      if (cmd_i.cand_inc) begin
        cand_q <= cand_q + 1'b1;
      end
      if (cmd_i.write_slot) begin
        next_id_q <= (cmd_q == pett_pkg::CMD_AUTO) ? cand_q + 1'b1 : max_new + 1'b1;
      end
    end
  end

  // Payload of the latched item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q     <= in_id_i;
      tmo_q    <= in_tmo_i;
      reason_q <= in_reason_i;
    end
  end

  // Slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.write_slot) valid_q[free_idx_q] <= 1'b1;
      if (cmd_i.clear_hit)  valid_q[hit_idx_q]  <= 1'b0;
      if (cmd_i.clear_best) valid_q[best_idx_q] <= 1'b0;
    end
  end

  // Scan: issue addresses and accumulate per-entry results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      rd_act_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      found_q  <= 1'b0;
      more_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_q   <= '0;
      rd_act_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      found_q  <= 1'b0;
      more_q   <= 1'b0;
    end else if (cmd_i.scan_step) begin
      rd_act_q <= (scan_q != ScanEnd);
      if (scan_q != ScanEnd) scan_q <= scan_q + 1'b1;
      if (ent_hit && !hit_q)   hit_q <= 1'b1;
      if (ent_free && !free_q) free_q <= 1'b1;
      if (ent_exp_hit) begin
        if (found_q) more_q <= 1'b1;
        found_q <= 1'b1;
      end
    end
  end

  // Scan payload accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      max_q <= '0;
    end else if (cmd_i.scan_step) begin
      rd_idx_q <= scan_q[IdxW-1:0];
      if (ent_hit && !hit_q)   hit_idx_q  <= rd_idx_q;
      if (ent_free && !free_q) free_idx_q <= rd_idx_q;
      if (rd_act_q && ent_v && ent_id > max_q) max_q <= ent_id;
      if (ent_exp_hit && (!found_q || ent_id < best_id_q)) begin
        best_id_q  <= ent_id;
        best_idx_q <= rd_idx_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q   <= cmd_i.emit_kind;
      out_last_q   <= cmd_i.emit_last;
      out_reason_q <= (cmd_i.emit_kind == pett_pkg::KIND_FAILURE) ? reason_q : '0;
      case (cmd_i.emit_id_sel)
        pett_pkg::ID_CAND:  out_id_q <= cand_q;
        pett_pkg::ID_EVENT: out_id_q <= id_q;
        pett_pkg::ID_BEST:  out_id_q <= best_id_q;
        default:            out_id_q <= '0;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_id_o     = out_id_q;
  assign out_reason_o = out_reason_q;
  assign out_last_o   = out_last_q;

  assign status_o.cmd        = cmd_q;
  assign status_o.scan_done  = (scan_q == ScanEnd) && !rd_act_q;
  assign status_o.hit        = hit_q;
  assign status_o.free_found = free_q;
  assign status_o.exp_found  = found_q;
  assign status_o.exp_more   = more_q;
  assign status_o.out_fire   = out_fire;

endmodule

@@ rtl/core/pending_event_tracker_timeout_core.sv @@
`timescale 1ns / 1ps
// Pending event tracker with timeout: top level joining controller and datapath.
// Depends on pett_pkg, pett_ctrl, pett_dp and pett_ram.
//
// Usage: commands enter on the s_axis channel (tuser carries the command code)
// and results leave on the m_axis channel (tuser carries the result kind,
// tlast marks the final result of a command). One command is worked on at a
// time; s_axis_tready_o is high only while the block is idle.
// Each table scan reads the slots in turn, paced by the single read port of
// the slot RAM; a pass is the launch, scan and decide states. Acks and
// explicit registers take one pass. An auto register takes one pass per id
// candidate it tries, up to TableDepth passes.
// A tick takes one pass per timeout reported, or one pass when nothing
// expires. Unknown acks and quiet ticks return to idle after their pass;
// unused command codes return to idle right after launch.
// Reset clears the valid bits, sets the next auto id to 1000 and time to
// zero; no clearing pass is needed. When the receiver stalls, the result
// holds in the output register and the block waits.

module pending_event_tracker_timeout_core #(
  parameter int TableDepth = pett_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: event_id [31:0], timeout_secs [48:32], reason_code [56:49], zero [63:57]
  input  logic [63:0] s_axis_tdata_i,
  // tuser: cmd [2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: result_id [31:0], result_reason [39:32]
  output logic [39:0] m_axis_tdata_o,
  // tuser: kind [2:0]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  pett_pkg::ctrl_cmd_t  ctrl_cmd;
  pett_pkg::dp_status_t dp_status;
  logic [pett_pkg::IdW-1:0]     res_id;
  logic [pett_pkg::ReasonW-1:0] res_reason;

  pett_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (dp_status),
    .cmd_o     (ctrl_cmd)
  );

  pett_dp #(
    .TableDepth(TableDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .in_cmd_i    (s_axis_tuser_i),
    .in_id_i     (s_axis_tdata_i[31:0]),
    .in_tmo_i    (s_axis_tdata_i[48:32]),
    .in_reason_i (s_axis_tdata_i[56:49]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_id_o    (res_id),
    .out_reason_o(res_reason),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {res_reason, res_id};

`ifndef NO_ASSERTIONS
  // A command is never taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input accepted while result pending");

  // Reason is nonzero only on failure results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[39:32] != 8'd0) |->
      (m_axis_tuser_o == pett_pkg::KIND_FAILURE))
    else $error("reason on non-failure result");

  // Only timeouts come in runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tuser_o == pett_pkg::KIND_TIMEOUT))
    else $error("non-final result that is not a timeout");
`endif

endmodule
